@@ hw/rtl/collatz_step_parity_cell_core_macros.svh @@
// assertion macros shared by the checker of the collatz cell core
// depends on clk and rst_n being visible where the macros are used
`ifndef COLLATZ_STEP_PARITY_CELL_CORE_MACROS_SVH
`define COLLATZ_STEP_PARITY_CELL_CORE_MACROS_SVH

// same-cycle implication
`define CSPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CSPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/cspc_pkg.sv @@
// types and constants of the collatz step parity cell core
// no dependencies; used by the core, its checker and the testbench
`default_nettype none

package cspc_pkg;

    localparam int DIM_MAX    = 4096;
    localparam int STEP_LIMIT = 10000;

    localparam int DIM_W   = 13;
    localparam int CELL_W  = 12;
    localparam int COUNT_W = 14;
    localparam int WORK_W  = 64;
    localparam int STEP_W  = $clog2(STEP_LIMIT + 1);
    localparam int IDX_W   = 2;

    localparam logic [IDX_W-1:0] REG_GRID_ROWS = 2'd0;
    localparam logic [IDX_W-1:0] REG_GRID_COLS = 2'd1;

    typedef struct packed {
        logic [CELL_W-1:0] cell_row;
        logic [CELL_W-1:0] cell_col;
    } cspc_in_t;

    typedef struct packed {
        logic               colored;
        logic [COUNT_W-1:0] step_count;
    } cspc_out_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MULT = 3'b010,
        S_RUN  = 3'b100
    } cspc_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/collatz_step_parity_cell_core.sv @@
// collatz step parity cell core: top level with sequencer and shared step unit
// depends on cspc_pkg
//
// usage
//   configuration: cfg_we with cfg_index selects grid_rows (0) or grid_cols (1);
//   cfg_data above DIM_MAX is saturated, other indexes are ignored. write only
//   while busy is low and no beat is in flight.
//   query: a beat is taken at a clock edge with start high and busy low.
//   result: done is high for one cycle with result valid; it cannot be held off.
//   sequence: the S_MULT state forms the start value with the multiplier, then
//   S_RUN works one collatz step per cycle on the shared 64-bit add/shift unit
//   until stepping stops, then finishes; busy stays high meanwhile and done follows in the
//   cycle busy drops. a cell outside the grid runs as a start value of one, with no steps.
//   one query is worked at a time: the single step unit takes no new query
//   until the last one is done.
//   a new query may be started in the same cycle that done is shown.
//   reset: grid size clears to zero, the sequencer goes idle, no done pulse.
`default_nettype none

module collatz_step_parity_cell_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire cspc_pkg::cspc_in_t             query,
    output logic                                done,
    output cspc_pkg::cspc_out_t                 result,
    input  wire logic                           cfg_we,
    input  wire logic [cspc_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [cspc_pkg::DIM_W-1:0]     cfg_data
);

    cspc_pkg::cspc_state_t            state_reg, state_next;
    logic [cspc_pkg::DIM_W-1:0]       grid_rows_reg, grid_cols_reg;
    logic [cspc_pkg::DIM_W-1:0]       cfg_clamped;
    logic [cspc_pkg::DIM_W-1:0]       row_span_reg, col_span_reg;
    logic [cspc_pkg::DIM_W-1:0]       row_rest, col_rest;
    logic [cspc_pkg::DIM_W-1:0]       row_ext, col_ext;
    logic                             in_range_reg;
    logic [cspc_pkg::WORK_W-1:0]      value_reg, value_next, value_step;
    logic [cspc_pkg::STEP_W-1:0]      count_reg, count_next;
    logic [2*cspc_pkg::DIM_W-1:0]     start_value;
    logic                             accept, stepping;
    logic                             done_reg, done_next;
    cspc_pkg::cspc_out_t              result_reg, result_next;

    assign accept = start && (state_reg == cspc_pkg::S_IDLE);
    assign busy   = (state_reg != cspc_pkg::S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // config saturation
    assign cfg_clamped = (cfg_data > cspc_pkg::DIM_W'(cspc_pkg::DIM_MAX))
                       ? cspc_pkg::DIM_W'(cspc_pkg::DIM_MAX) : cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= '0;
            grid_cols_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cspc_pkg::REG_GRID_ROWS: grid_rows_reg <= cfg_clamped;
                cspc_pkg::REG_GRID_COLS: grid_cols_reg <= cfg_clamped;
                default: ;
            endcase
        end
    end

    // spans from the cell to the far edge
    assign row_ext  = {1'b0, query.cell_row};
    assign col_ext  = {1'b0, query.cell_col};
    assign row_rest = grid_rows_reg - row_ext;
    assign col_rest = grid_cols_reg - col_ext;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_span_reg <= (row_ext > row_rest) ? row_ext : row_rest;
            col_span_reg <= (col_ext > col_rest) ? col_ext : col_rest;
            in_range_reg <= (row_ext < grid_rows_reg) && (col_ext < grid_cols_reg);
        end
    end

    assign start_value = row_span_reg * col_span_reg;

    // shared step unit
    assign value_step = value_reg[0]
                      ? ((value_reg << 1) + value_reg + cspc_pkg::WORK_W'(1))
                      : (value_reg >> 1);
    assign stepping   = (value_reg > cspc_pkg::WORK_W'(1))
                      && (count_reg < cspc_pkg::STEP_W'(cspc_pkg::STEP_LIMIT));

    always_comb
    begin
        state_next  = state_reg;
        value_next  = value_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        unique case (state_reg)
            cspc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = cspc_pkg::S_MULT;
                end
            end
            cspc_pkg::S_MULT:
            begin
                // outside the grid runs as a start value of one
                value_next = in_range_reg ? cspc_pkg::WORK_W'(start_value)
                                          : cspc_pkg::WORK_W'(1);
                count_next = '0;
                state_next = cspc_pkg::S_RUN;
            end
            cspc_pkg::S_RUN:
            begin
                if (stepping)
                begin
                    value_next = value_step;
                    count_next = count_reg + cspc_pkg::STEP_W'(1);
                end
                else
                begin
                    result_next.colored    = count_reg[0];
                    result_next.step_count = cspc_pkg::COUNT_W'(count_reg);
                    done_next              = 1'b1;
                    state_next             = cspc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cspc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cspc_pkg::S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        count_reg  <= count_next;
        result_reg <= result_next;
    end

endmodule

`default_nettype wire

@@ hw/rtl/cspc_checker.sv @@
// port-level checker for the collatz cell core, bound to the top level
// depends on cspc_pkg and collatz_step_parity_cell_core_macros.svh
`default_nettype none
`include "collatz_step_parity_cell_core_macros.svh"

module cspc_checker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic                busy,
    input  wire logic                done,
    input  wire cspc_pkg::cspc_out_t result
);

    `CSPC_ASSERT_NOW(a_done_idle, done, !busy, "done beat while busy")
    `CSPC_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted beat did not raise busy")
    `CSPC_ASSERT_NOW(a_busy_fall_done, $fell(busy), done, "busy dropped without a done beat")
    `CSPC_ASSERT_NOW(a_count_cap, done, result.step_count <= cspc_pkg::COUNT_W'(cspc_pkg::STEP_LIMIT), "step count above limit")
    `CSPC_ASSERT_NOW(a_colour_parity, done && result.colored, result.step_count[0], "coloured with even count")

endmodule

bind collatz_step_parity_cell_core cspc_checker u_cspc_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire

@@ tb/sv/tb_collatz_step_parity_cell_core.sv @@
// testbench of the collatz step parity cell core: directed and random queries over
// several grid sizes, results checked against a collatz step predictor
// depends on cspc_pkg and collatz_step_parity_cell_core
module tb_collatz_step_parity_cell_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [cspc_pkg::IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [cspc_pkg::IDX_W-1:0] REG_SPARE_3 = 2'd3;
    localparam int STALL_LIMIT  = 4 * (cspc_pkg::STEP_LIMIT + 3) + 200;
    localparam int RANDOM_ITEMS = 630;
    localparam int RANDOM_SETS  = 8;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    cspc_pkg::cspc_in_t            query;
    logic                          done;
    cspc_pkg::cspc_out_t           result;
    logic                          cfg_we;
    logic [cspc_pkg::IDX_W-1:0]    cfg_index;
    logic [cspc_pkg::DIM_W-1:0]    cfg_data;

    cspc_pkg::cspc_in_t            query_backlog[$];
    cspc_pkg::cspc_out_t           expected_results[$];
    logic [cspc_pkg::DIM_W-1:0]    grid_rows;
    logic [cspc_pkg::DIM_W-1:0]    grid_cols;
    int                            mismatch_count;
    int                            quiet_cycles;
    int unsigned                   burst_left;
    int unsigned                   gap_left;
    logic                          drain_hold;

    collatz_step_parity_cell_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .query     (query),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic cspc_pkg::cspc_out_t collatz_cell_result(cspc_pkg::cspc_in_t query_beat);
        logic [cspc_pkg::DIM_W-1:0] row_ext;
        logic [cspc_pkg::DIM_W-1:0] col_ext;
        logic [cspc_pkg::DIM_W-1:0] rows_left;
        logic [cspc_pkg::DIM_W-1:0] cols_left;
        logic [cspc_pkg::DIM_W-1:0] row_span;
        logic [cspc_pkg::DIM_W-1:0] col_span;
        logic [63:0]                value;
        int unsigned                count;
        cspc_pkg::cspc_out_t        res;
        res     = '0;
        count   = 0;
        row_ext = {1'b0, query_beat.cell_row};
        col_ext = {1'b0, query_beat.cell_col};
        if (row_ext < grid_rows && col_ext < grid_cols)
        begin
            rows_left = grid_rows - row_ext;
            cols_left = grid_cols - col_ext;
            row_span  = (row_ext > rows_left) ? row_ext : rows_left;
            col_span  = (col_ext > cols_left) ? col_ext : cols_left;
            value     = 64'(row_span) * 64'(col_span);
            while (value > 64'd1 && count < cspc_pkg::STEP_LIMIT)
            begin
                if (value[0] == 1'b0)
                    value = value >> 1;
                else
                    value = 64'd3 * value + 64'd1;
                count++;
            end
            res.colored    = count[0];
            res.step_count = count[cspc_pkg::COUNT_W-1:0];
        end
        return res;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic write_grid_reg(input logic [cspc_pkg::IDX_W-1:0] idx,
                                  input logic [cspc_pkg::DIM_W-1:0] data);
        logic [cspc_pkg::DIM_W-1:0] held;
        held = (data > cspc_pkg::DIM_W'(cspc_pkg::DIM_MAX))
             ? cspc_pkg::DIM_W'(cspc_pkg::DIM_MAX) : data;
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            cspc_pkg::REG_GRID_ROWS: grid_rows = held;
            cspc_pkg::REG_GRID_COLS: grid_cols = held;
            default: ;
        endcase
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_data  <= '0;
    endtask

    task automatic add_cell(input int unsigned row, input int unsigned col);
        cspc_pkg::cspc_in_t entry;
        entry.cell_row = row[cspc_pkg::CELL_W-1:0];
        entry.cell_col = col[cspc_pkg::CELL_W-1:0];
        query_backlog.push_back(entry);
    endtask

    task automatic wait_drained();
        while (query_backlog.size() != 0 || expected_results.size() != 0 || start || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [cspc_pkg::DIM_W-1:0] pick_dim();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 2)
            return cspc_pkg::DIM_W'($urandom_range(0, 8191));
        else if (pick < 4)
            return cspc_pkg::DIM_W'(cspc_pkg::DIM_MAX);
        else if (pick < 6)
            return cspc_pkg::DIM_W'($urandom_range(1, 8));
        else if (pick < 8)
            return cspc_pkg::DIM_W'($urandom_range(1, cspc_pkg::DIM_MAX));
        else if (pick < 9)
            return cspc_pkg::DIM_W'(8191);
        return '0;
    endfunction

    function automatic int unsigned pick_index(input logic [cspc_pkg::DIM_W-1:0] span);
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (span == 0 || pick < 3)
            return $urandom_range(0, 4095);
        else if (pick == 3)
            return 0;
        else if (pick == 4)
            return span - 1;
        return $urandom_range(0, span - 1);
    endfunction

    // sender: bursts of beats with random gaps, now and then holding until drained
    always @(posedge clk or negedge rst_n)
    begin : driver
        logic               launch;
        cspc_pkg::cspc_in_t next_query;
        int unsigned        pick;
        if (!rst_n)
        begin
            start      <= 1'b0;
            query      <= '0;
            burst_left = 0;
            gap_left   = 0;
            drain_hold = 1'b0;
        end
        else
        begin
            launch     = start;
            next_query = query;
            if (start && !busy)
            begin
                expected_results.push_back(collatz_cell_result(query));
                launch = 1'b0;
            end
            if (!launch)
            begin
                next_query = 24'($urandom);
                if (drain_hold && expected_results.size() == 0)
                    drain_hold = 1'b0;
                if (gap_left != 0)
                    gap_left--;
                else if (!drain_hold && query_backlog.size() != 0)
                begin
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 16);
                    next_query = query_backlog.pop_front();
                    launch     = 1'b1;
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        pick = $urandom_range(0, 19);
                        if (pick < 6)
                            gap_left = 0;
                        else if (pick < 17)
                            gap_left = $urandom_range(1, 8);
                        else if (pick < 19)
                            gap_left = $urandom_range(20, 60);
                        else
                            drain_hold = 1'b1;
                    end
                end
            end
            start <= launch;
            query <= next_query;
        end
    end

    always @(posedge clk)
    begin : monitor
        cspc_pkg::cspc_out_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
                flag_mismatch("result beat with nothing pending");
            else
            begin
                want = expected_results.pop_front();
                if (result.colored !== want.colored)
                    flag_mismatch($sformatf("colored got %0b want %0b",
                                            result.colored, want.colored));
                if (result.step_count !== want.step_count)
                    flag_mismatch($sformatf("step_count got %0d want %0d",
                                            result.step_count, want.step_count));
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (start && !busy) || done)
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned set_items;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        grid_rows      = '0;
        grid_cols      = '0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // grid of zero size after reset
        add_cell(0, 0);
        add_cell(4095, 4095);
        wait_drained();

        // rows saturated, cols still zero
        write_grid_reg(cspc_pkg::REG_GRID_ROWS, 13'd8191);
        add_cell(0, 0);
        wait_drained();

        write_grid_reg(cspc_pkg::REG_GRID_COLS, 13'd4097);
        add_cell(0, 0);
        add_cell(4095, 4095);
        add_cell(2048, 2048);
        add_cell(4095, 0);
        add_cell(0, 4095);
        add_cell(2730, 1365);
        add_cell(12'hAAA, 12'h555);
        add_cell(12'h555, 12'hAAA);
        wait_drained();

        // writes to unused indexes leave the grid alone
        write_grid_reg(REG_SPARE_2, 13'd0);
        write_grid_reg(REG_SPARE_3, 13'd8191);
        add_cell(100, 200);
        add_cell(4095, 4095);
        wait_drained();

        // start value of one and tiny grids
        write_grid_reg(cspc_pkg::REG_GRID_ROWS, 13'd1);
        write_grid_reg(cspc_pkg::REG_GRID_COLS, 13'd2);
        add_cell(0, 1);
        add_cell(0, 0);
        add_cell(1, 0);
        add_cell(0, 2);
        wait_drained();
        write_grid_reg(cspc_pkg::REG_GRID_ROWS, 13'd2);
        write_grid_reg(cspc_pkg::REG_GRID_COLS, 13'd1);
        add_cell(1, 0);
        add_cell(0, 0);
        wait_drained();
        write_grid_reg(cspc_pkg::REG_GRID_ROWS, 13'd3);
        write_grid_reg(cspc_pkg::REG_GRID_COLS, 13'd3);
        add_cell(1, 1);
        add_cell(0, 0);
        wait_drained();

        for (int s = 0; s < RANDOM_SETS; s++)
        begin
            if ($urandom_range(0, 3) == 0)
                write_grid_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                               cspc_pkg::DIM_W'($urandom_range(0, 8191)));
            if (s == RANDOM_SETS - 1)
            begin
                write_grid_reg(cspc_pkg::REG_GRID_ROWS, cspc_pkg::DIM_W'(cspc_pkg::DIM_MAX));
                write_grid_reg(cspc_pkg::REG_GRID_COLS, cspc_pkg::DIM_W'(cspc_pkg::DIM_MAX));
            end
            else
            begin
                write_grid_reg(cspc_pkg::REG_GRID_ROWS, pick_dim());
                write_grid_reg(cspc_pkg::REG_GRID_COLS, pick_dim());
            end
            set_items = RANDOM_ITEMS / RANDOM_SETS;
            for (int n = 0; n < set_items; n++)
                add_cell(pick_index(grid_rows), pick_index(grid_cols));
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (expected_results.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ collatz_step_parity_cell_core.f @@
+incdir+hw/rtl
hw/rtl/cspc_pkg.sv
hw/rtl/collatz_step_parity_cell_core.sv
hw/rtl/cspc_checker.sv
tb/sv/tb_collatz_step_parity_cell_core.sv
